### hw/rtl/great_circle_time_shift_defines.svh
// Assertion macros used by the checker of the great-circle time shift block.
`ifndef GREAT_CIRCLE_TIME_SHIFT_DEFINES_SVH
`define GREAT_CIRCLE_TIME_SHIFT_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define GCTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: great-circle time shift check failed");

// Checks the consequent in the cycle after the antecedent.
`define GCTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: great-circle time shift check failed");

`endif

### hw/rtl/gcts_pkg.sv
// Types, constants and arithmetic helpers of the great-circle time shift block.
package gcts_pkg;

  localparam int unsigned TRIG_ITERATIONS = 24;

  // Datapath width of CORDIC and vector values (Q30 with headroom).
  localparam int unsigned CW = 34;
  // Width of a product of two CW values plus room for a sum of three.
  localparam int unsigned PW = 2 * CW + 2;

  // Register stages of one arc pipeline and of the whole block.
  localparam int unsigned ARC_LAT = 4 * TRIG_ITERATIONS + 15;
  localparam int unsigned PIPE_DEPTH = ARC_LAT + 4;

  // Field widths.
  localparam int unsigned LAT_W = 24;
  localparam int unsigned LON_W = 25;
  localparam int unsigned DEP_W = 19;
  localparam int unsigned ASLW_W = 22;
  localparam int unsigned DSLW_W = 26;
  localparam int unsigned TS_W = 30;
  localparam int unsigned DEG_W = 24;
  localparam int unsigned ANG_W = 27;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 26;
  localparam int unsigned IN_TDATA_W = 72;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  // Angle constants, degrees Q16.
  localparam logic signed [ANG_W-1:0] DEG90_Q16 = 27'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360_Q16 = 27'sd23592960;
  localparam logic [DEG_W-1:0] DEG180_U = 24'd11796480;

  // Degrees Q16 to radians Q30 scale (Q40) and rounding term for the shift by 26.
  localparam logic signed [35:0] D2R_Q40 = 36'sd19190098067;
  localparam logic signed [59:0] RND26 = 60'sd33554432;

  // Radians Q30 to degrees Q16 scale (Q24) and rounding term for the shift by 38.
  localparam logic [29:0] R2D_Q24 = 30'd961263669;
  localparam logic [61:0] RND38 = 62'd137438953472;

  localparam logic signed [CW-1:0] CORDIC_K = CW'(64'd652032874);
  localparam logic signed [CW-1:0] PI_HALF_Q30 = CW'(64'd1686629713);
  localparam logic signed [CW-1:0] PI_Q30 = CW'(64'd3373259426);
  localparam logic signed [PW-1:0] RND30 = PW'(64'd536870912);

  // Output range, seconds Q16.
  localparam logic signed [31:0] SHIFT_MAX = 32'sd288358400;
  localparam logic signed [31:0] SHIFT_MIN = -32'sd288358400;
  localparam logic signed [47:0] RND16 = 48'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STA_LAT = 3'd0,
    REG_STA_LON = 3'd1,
    REG_REF_LAT = 3'd2,
    REG_REF_LON = 3'd3,
    REG_REF_DEP = 3'd4,
    REG_ARC_SLW = 3'd5,
    REG_DEP_SLW = 3'd6
  } cfg_reg_e;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Arctangent of 2^-i in radians Q30; zero past the table.
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic signed [CW-1:0] r;
    r = '0;
    if (i < 32) r = CW'(ATAN_TAB[i[4:0]]);
    return r;
  endfunction

  // One rotation-mode CORDIC step.
  function automatic cordic_t rot_step(input cordic_t c, input int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] dx, dy, at;
    dx = c.x >>> i;
    dy = c.y >>> i;
    at = atan_q30(i);
    if (!c.z[CW-1]) begin
      r.x = c.x - dy;
      r.y = c.y + dx;
      r.z = c.z - at;
    end else begin
      r.x = c.x + dy;
      r.y = c.y - dx;
      r.z = c.z + at;
    end
    return r;
  endfunction

  // One vectoring-mode CORDIC step.
  function automatic cordic_t vec_step(input cordic_t c, input int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] dx, dy, at;
    dx = c.x >>> i;
    dy = c.y >>> i;
    at = atan_q30(i);
    if (!c.y[CW-1]) begin
      r.x = c.x + dy;
      r.y = c.y - dx;
      r.z = c.z + at;
    end else begin
      r.x = c.x - dy;
      r.y = c.y + dx;
      r.z = c.z - at;
    end
    return r;
  endfunction

  // Signed product, sign-extended to PW.
  function automatic logic signed [PW-1:0] smul(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] r;
    r = a * b;
    return PW'(r);
  endfunction

  // Round half up from Q60 back to Q30.
  function automatic logic signed [CW-1:0] rnd30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + RND30;
    return t[30 +: CW];
  endfunction

  function automatic logic signed [CW-1:0] sabs(input logic signed [CW-1:0] v);
    return v[CW-1] ? -v : v;
  endfunction

endpackage

### hw/rtl/gcts_arc.sv
// Pipelined great-circle arc between two points, in degrees Q16.
module gcts_arc (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [gcts_pkg::LAT_W-1:0]   lat1_i,
  input  logic signed [gcts_pkg::LON_W-1:0]   lon1_i,
  input  logic signed [gcts_pkg::LAT_W-1:0]   lat2_i,
  input  logic signed [gcts_pkg::LON_W-1:0]   lon2_i,
  output logic        [gcts_pkg::DEG_W-1:0]   deg_o,
  output logic                                flag_o
);

  localparam int unsigned N = gcts_pkg::TRIG_ITERATIONS;
  localparam int unsigned CW = gcts_pkg::CW;
  localparam int unsigned PW = gcts_pkg::PW;
  localparam int unsigned AW = gcts_pkg::ANG_W;

  // Lanes: 0 colatitude of point 1, 1 longitude of point 1, 2 and 3 the same for point 2.
  logic signed [AW-1:0] ang_raw [4];
  logic signed [AW-1:0] ang_fld [4];
  logic                 ang_neg [4];

  always_comb begin
    logic signed [AW-1:0] red;
    ang_raw[0] = gcts_pkg::DEG90_Q16 - AW'(lat1_i);
    ang_raw[1] = AW'(lon1_i);
    ang_raw[2] = gcts_pkg::DEG90_Q16 - AW'(lat2_i);
    ang_raw[3] = AW'(lon2_i);
    for (int l = 0; l < 4; l++) begin
      red = ang_raw[l];
      if (ang_raw[l] > gcts_pkg::DEG180_Q16) red = ang_raw[l] - gcts_pkg::DEG360_Q16;
      else if (ang_raw[l] < -gcts_pkg::DEG180_Q16) red = ang_raw[l] + gcts_pkg::DEG360_Q16;
      // Fold into the right half plane; sine and cosine change sign.
      ang_fld[l] = red;
      ang_neg[l] = 1'b0;
      if (red > gcts_pkg::DEG90_Q16) begin
        ang_fld[l] = red - gcts_pkg::DEG180_Q16;
        ang_neg[l] = 1'b1;
      end else if (red < -gcts_pkg::DEG90_Q16) begin
        ang_fld[l] = red + gcts_pkg::DEG180_Q16;
        ang_neg[l] = 1'b1;
      end
    end
  end

  logic signed [23:0]       af_q   [4];
  logic signed [59:0]       azp_q  [4];
  logic                     neg_q  [4][N+3];
  gcts_pkg::cordic_t        rot_q  [4][N+1];
  logic signed [CW-1:0]     sin_q  [4];
  logic signed [CW-1:0]     cos_q  [4];
  logic signed [PW-1:0]     up_q   [2][2];
  logic signed [CW-1:0]     ct_q   [2];
  logic signed [CW-1:0]     va_q   [2][3];
  logic signed [PW-1:0]     dp_q   [9];
  gcts_pkg::cordic_t        va_c_q [N+1];
  logic signed [CW-1:0]     c2a_q  [N+1];
  logic signed [CW-1:0]     da_q   [N+1];
  logic signed [PW-1:0]     ma_q;
  logic signed [CW-1:0]     c2m_q;
  logic signed [CW-1:0]     dm_q;
  gcts_pkg::cordic_t        vb_q   [N+1];
  logic signed [CW-1:0]     db_q   [N+1];
  logic signed [PW-1:0]     mb_q;
  logic signed [CW-1:0]     dmb_q;
  gcts_pkg::cordic_t        vc_q   [N+1];
  logic              [31:0] arc_q;
  logic              [61:0] dgp_q;
  logic [gcts_pkg::DEG_W-1:0] deg_q;
  logic                     flag_q;

  logic signed [59:0] zr [4];
  logic signed [CW-1:0] dot_d, c0_d, c1_d, c2_d;
  logic signed [CW:0]   arc_raw;
  logic        [61:0]   dgr;
  logic [gcts_pkg::DEG_W-1:0] deg_r, deg_c;

  always_comb begin
    for (int l = 0; l < 4; l++) zr[l] = azp_q[l] + gcts_pkg::RND26;
    dot_d = gcts_pkg::rnd30(dp_q[0] + dp_q[1] + dp_q[2]);
    c0_d  = gcts_pkg::rnd30(dp_q[3] - dp_q[4]);
    c1_d  = gcts_pkg::rnd30(dp_q[5] - dp_q[6]);
    c2_d  = gcts_pkg::rnd30(dp_q[7] - dp_q[8]);
    // The arc is pi/2 minus the angle of the last vectoring pass.
    arc_raw = (CW+1)'(gcts_pkg::PI_HALF_Q30) - (CW+1)'(vc_q[N].z);
    dgr = dgp_q + gcts_pkg::RND38;
    deg_r = dgr[61:38];
    deg_c = (deg_r > gcts_pkg::DEG180_U) ? gcts_pkg::DEG180_U : deg_r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Angle reduction, scaling to radians, and the sine/cosine rotations.
      for (int l = 0; l < 4; l++) begin
        af_q[l]     <= ang_fld[l][23:0];
        neg_q[l][0] <= ang_neg[l];
        azp_q[l]    <= af_q[l] * gcts_pkg::D2R_Q40;
        for (int k = 1; k < N + 3; k++) neg_q[l][k] <= neg_q[l][k-1];
        rot_q[l][0].x <= gcts_pkg::CORDIC_K;
        rot_q[l][0].y <= '0;
        rot_q[l][0].z <= zr[l][26 +: CW];
        for (int unsigned k = 0; k < N; k++) begin
          rot_q[l][k+1] <= gcts_pkg::rot_step(rot_q[l][k], k);
        end
        sin_q[l] <= neg_q[l][N+2] ? -rot_q[l][N].y : rot_q[l][N].y;
        cos_q[l] <= neg_q[l][N+2] ? -rot_q[l][N].x : rot_q[l][N].x;
      end

      // Unit vectors (sin t cos p, sin t sin p, cos t).
      for (int p = 0; p < 2; p++) begin
        up_q[p][0] <= gcts_pkg::smul(sin_q[2*p], cos_q[2*p+1]);
        up_q[p][1] <= gcts_pkg::smul(sin_q[2*p], sin_q[2*p+1]);
        ct_q[p]    <= cos_q[2*p];
        va_q[p][0] <= gcts_pkg::rnd30(up_q[p][0]);
        va_q[p][1] <= gcts_pkg::rnd30(up_q[p][1]);
        va_q[p][2] <= ct_q[p];
      end

      // Products for the dot product and the three cross-product terms.
      dp_q[0] <= gcts_pkg::smul(va_q[0][0], va_q[1][0]);
      dp_q[1] <= gcts_pkg::smul(va_q[0][1], va_q[1][1]);
      dp_q[2] <= gcts_pkg::smul(va_q[0][2], va_q[1][2]);
      dp_q[3] <= gcts_pkg::smul(va_q[0][1], va_q[1][2]);
      dp_q[4] <= gcts_pkg::smul(va_q[0][2], va_q[1][1]);
      dp_q[5] <= gcts_pkg::smul(va_q[0][2], va_q[1][0]);
      dp_q[6] <= gcts_pkg::smul(va_q[0][0], va_q[1][2]);
      dp_q[7] <= gcts_pkg::smul(va_q[0][0], va_q[1][1]);
      dp_q[8] <= gcts_pkg::smul(va_q[0][1], va_q[1][0]);

      // First vectoring pass: magnitude of the first two cross terms.
      va_c_q[0].x <= gcts_pkg::sabs(c0_d);
      va_c_q[0].y <= c1_d;
      va_c_q[0].z <= '0;
      c2a_q[0]    <= c2_d;
      da_q[0]     <= dot_d;
      for (int unsigned k = 0; k < N; k++) begin
        va_c_q[k+1] <= gcts_pkg::vec_step(va_c_q[k], k);
        c2a_q[k+1]  <= c2a_q[k];
        da_q[k+1]   <= da_q[k];
      end
      ma_q  <= gcts_pkg::smul(va_c_q[N].x, gcts_pkg::CORDIC_K);
      c2m_q <= c2a_q[N];
      dm_q  <= da_q[N];

      // Second pass: full cross-product magnitude.
      vb_q[0].x <= gcts_pkg::rnd30(ma_q);
      vb_q[0].y <= gcts_pkg::sabs(c2m_q);
      vb_q[0].z <= '0;
      db_q[0]   <= dm_q;
      for (int unsigned k = 0; k < N; k++) begin
        vb_q[k+1] <= gcts_pkg::vec_step(vb_q[k], k);
        db_q[k+1] <= db_q[k];
      end
      mb_q  <= gcts_pkg::smul(vb_q[N].x, gcts_pkg::CORDIC_K);
      dmb_q <= db_q[N];

      // Third pass: angle between the cross magnitude and the dot product.
      vc_q[0].x <= gcts_pkg::rnd30(mb_q);
      vc_q[0].y <= dmb_q;
      vc_q[0].z <= '0;
      for (int unsigned k = 0; k < N; k++) begin
        vc_q[k+1] <= gcts_pkg::vec_step(vc_q[k], k);
      end

      // Clamp, convert to degrees, clamp again and flag the antipode.
      if (arc_raw[CW]) arc_q <= '0;
      else if (arc_raw > (CW+1)'(gcts_pkg::PI_Q30)) arc_q <= gcts_pkg::PI_Q30[31:0];
      else arc_q <= arc_raw[31:0];
      dgp_q  <= arc_q * gcts_pkg::R2D_Q24;
      deg_q  <= deg_c;
      flag_q <= (deg_c >= gcts_pkg::DEG180_U - 24'd1);
    end
  end

  assign deg_o  = deg_q;
  assign flag_o = flag_q;

endmodule

### hw/rtl/great_circle_time_shift.sv
// Top level of the great-circle travel-time shift pipeline.
//
//  Channel  | Direction | Signals                          | Payload
//  ---------+-----------+----------------------------------+------------------------------------
//  s_axis   | in        | tvalid, tready, tdata[71:0]      | candidate latitude, longitude, depth
//  m_axis   | out       | tvalid, tready, tdata[31:0], tuser| time shift, saturated/arc flags
//  cfg      | in        | cfg_we_i, cfg_idx_i, cfg_data_i  | station, reference, slownesses
//
// One transaction is accepted per clock cycle while m_axis is not stalled. Each result
// passes through the four chained CORDIC passes (sine/cosine, then three vectoring
// passes) of each arc before it reaches m_axis.
// Reset clears the valid bits and the configuration registers to zero.
// When a result waits on m_axis and m_axis_tready is low, the whole pipeline holds
// and s_axis_tready drops; no transaction is lost or repeated.
module great_circle_time_shift (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Fields from bit 0: detected_latitude[23:0], detected_longitude[48:24],
  // detected_depth[67:49], zero padding[71:68].
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [gcts_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // Fields from bit 0: time_shift[29:0], zero padding[31:30].
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [gcts_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // Fields from bit 0: shift_saturated[0], arc_undetermined[1].
  output logic [gcts_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic [gcts_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gcts_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned L = gcts_pkg::ARC_LAT;
  localparam int unsigned D = gcts_pkg::PIPE_DEPTH;

  // Configuration registers.
  logic signed [gcts_pkg::LAT_W-1:0]  sta_lat_q, ref_lat_q;
  logic signed [gcts_pkg::LON_W-1:0]  sta_lon_q, ref_lon_q;
  logic signed [gcts_pkg::DEP_W-1:0]  ref_dep_q;
  logic signed [gcts_pkg::ASLW_W-1:0] arc_slw_q;
  logic signed [gcts_pkg::DSLW_W-1:0] dep_slw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sta_lat_q <= '0;
      sta_lon_q <= '0;
      ref_lat_q <= '0;
      ref_lon_q <= '0;
      ref_dep_q <= '0;
      arc_slw_q <= '0;
      dep_slw_q <= '0;
    end else if (cfg_we_i) begin
      case (gcts_pkg::cfg_reg_e'(cfg_idx_i))
        gcts_pkg::REG_STA_LAT: sta_lat_q <= cfg_data_i[gcts_pkg::LAT_W-1:0];
        gcts_pkg::REG_STA_LON: sta_lon_q <= cfg_data_i[gcts_pkg::LON_W-1:0];
        gcts_pkg::REG_REF_LAT: ref_lat_q <= cfg_data_i[gcts_pkg::LAT_W-1:0];
        gcts_pkg::REG_REF_LON: ref_lon_q <= cfg_data_i[gcts_pkg::LON_W-1:0];
        gcts_pkg::REG_REF_DEP: ref_dep_q <= cfg_data_i[gcts_pkg::DEP_W-1:0];
        gcts_pkg::REG_ARC_SLW: arc_slw_q <= cfg_data_i[gcts_pkg::ASLW_W-1:0];
        gcts_pkg::REG_DEP_SLW: dep_slw_q <= cfg_data_i[gcts_pkg::DSLW_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic signed [gcts_pkg::LAT_W-1:0] det_lat;
  logic signed [gcts_pkg::LON_W-1:0] det_lon;
  logic signed [gcts_pkg::DEP_W-1:0] det_dep;

  assign det_lat = s_axis_tdata[23:0];
  assign det_lon = s_axis_tdata[48:24];
  assign det_dep = s_axis_tdata[67:49];

  // The pipeline moves as one; it holds only while a result waits unaccepted.
  logic        pipe_en;
  logic [D-1:0] vld_q;

  assign pipe_en       = !vld_q[D-1] || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[D-2:0], s_axis_tvalid};
    end
  end

  // Two arc pipelines: station to candidate, and station to reference event.
  logic [gcts_pkg::DEG_W-1:0] deg_evt, deg_ref;
  logic                       flag_evt, flag_ref;

  gcts_arc u_arc_evt (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .lat1_i (sta_lat_q),
    .lon1_i (sta_lon_q),
    .lat2_i (det_lat),
    .lon2_i (det_lon),
    .deg_o  (deg_evt),
    .flag_o (flag_evt)
  );

  gcts_arc u_arc_ref (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .lat1_i (sta_lat_q),
    .lon1_i (sta_lon_q),
    .lat2_i (ref_lat_q),
    .lon2_i (ref_lon_q),
    .deg_o  (deg_ref),
    .flag_o (flag_ref)
  );

  // Candidate depth travels alongside the arc pipelines.
  logic signed [gcts_pkg::DEP_W-1:0] dep_q [L];

  // Combination stages: differences, products, rounded sum, saturated output.
  logic signed [24:0] dg_q;
  logic signed [19:0] dd_q;
  logic signed [46:0] pa_q;
  logic signed [45:0] pd_q;
  logic signed [31:0] ts_q;
  logic               flg1_q, flg2_q, flg3_q;
  logic signed [47:0] sum_d;
  logic [gcts_pkg::TS_W-1:0] out_ts_q;
  logic               out_sat_q, out_flag_q;

  assign sum_d = 48'(pa_q) + 48'(pd_q) + gcts_pkg::RND16;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dep_q[0] <= det_dep;
      for (int k = 1; k < L; k++) dep_q[k] <= dep_q[k-1];

      dg_q   <= $signed({1'b0, deg_evt}) - $signed({1'b0, deg_ref});
      dd_q   <= 20'(dep_q[L-1]) - 20'(ref_dep_q);
      flg1_q <= flag_evt || flag_ref;

      pa_q   <= arc_slw_q * dg_q;
      pd_q   <= dep_slw_q * dd_q;
      flg2_q <= flg1_q;

      ts_q   <= sum_d[47:16];
      flg3_q <= flg2_q;

      // Clip to the output range and note when that happened.
      if (ts_q > gcts_pkg::SHIFT_MAX) begin
        out_ts_q  <= gcts_pkg::SHIFT_MAX[gcts_pkg::TS_W-1:0];
        out_sat_q <= 1'b1;
      end else if (ts_q < gcts_pkg::SHIFT_MIN) begin
        out_ts_q  <= gcts_pkg::SHIFT_MIN[gcts_pkg::TS_W-1:0];
        out_sat_q <= 1'b1;
      end else begin
        out_ts_q  <= ts_q[gcts_pkg::TS_W-1:0];
        out_sat_q <= 1'b0;
      end
      out_flag_q <= flg3_q;
    end
  end

  assign m_axis_tvalid = vld_q[D-1];
  assign m_axis_tdata  = {2'b00, out_ts_q};
  assign m_axis_tuser  = {out_flag_q, out_sat_q};

endmodule

### hw/rtl/gcts_chk.sv
// Port-level checker for the great-circle time shift block, bound to the top level.
`include "great_circle_time_shift_defines.svh"

module gcts_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [gcts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [gcts_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  // A result that is not taken stays put.
  `GCTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Input back-pressure only comes from a stalled result.
  `GCTS_ASSERT_NOW(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // A valid time shift never leaves the clip range.
  `GCTS_ASSERT_NOW(a_ts_range, m_axis_tvalid, ($signed(m_axis_tdata[29:0]) <= gcts_pkg::SHIFT_MAX) && ($signed(m_axis_tdata[29:0]) >= gcts_pkg::SHIFT_MIN))

  // A saturated result sits exactly on one of the two limits.
  `GCTS_ASSERT_NOW(a_sat_limit, m_axis_tvalid && m_axis_tuser[0], ($signed(m_axis_tdata[29:0]) == gcts_pkg::SHIFT_MAX) || ($signed(m_axis_tdata[29:0]) == gcts_pkg::SHIFT_MIN))

endmodule

bind great_circle_time_shift gcts_chk u_gcts_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/tb.sv
// Self-checking testbench for the great-circle travel-time shift pipeline.
`timescale 1ns / 100ps

module tb;
  import gcts_pkg::*;

  // Fixed-point constants of the arithmetic, kept at 64 bits for the predictor.
  localparam longint QDEG90 = 64'sd5898240;
  localparam longint QDEG180 = 64'sd11796480;
  localparam longint QDEG360 = 64'sd23592960;
  localparam longint DEG_TO_RAD = 64'sd19190098067;
  localparam longint RAD_TO_DEG = 64'sd961263669;
  localparam longint INV_GAIN = 64'sd652032874;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint FULL_PI = 64'sd3373259426;
  localparam longint CLIP = 64'sd288358400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int NUM_REGS = 7;
  localparam int DRAIN_CYCLES = 4 * TRIG_ITERATIONS + 40;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  great_circle_time_shift dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One expected result: the shift and its two flags.
  typedef struct {
    logic [TS_W-1:0] shift;
    bit sat;
    bit undet;
  } shift_result_t;

  // One row of the directed table. Where known_shift is set and use_typed is on, the shift
  // and the saturation flag are typed in; the arc flag always comes from the predictor.
  typedef struct {
    longint lat;
    longint lon;
    longint dep;
    bit known_shift;
    longint shift;
  } probe_row_t;

  shift_result_t shift_q[$];
  probe_row_t probe_table[$];
  bit typed_valid[$];
  shift_result_t typed_q[$];

  // Register shadows, sign extended.
  longint regs_now[NUM_REGS];
  int unsigned reg_width[NUM_REGS] = '{LAT_W, LON_W, LAT_W, LON_W, DEP_W, ASLW_W, DSLW_W};

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int err_cnt = 0;
  int idle_cycles = 0;
  bit use_typed = 1'b0;

  function automatic longint sx(input longint v, input int unsigned w);
    longint m;
    m = v & ((longint'(1) << w) - 1);
    if (m[w-1]) m = m - (longint'(1) << w);
    return m;
  endfunction

  function automatic longint rshr(input longint v, input int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_at(input int unsigned i);
    return (i < 32) ? longint'(ATAN_TAB[i]) : 64'sd0;
  endfunction

  // Rotation CORDIC: sine and cosine (Q30) of an angle in degrees Q16.
  function automatic void sine_cosine(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = INV_GAIN;
    y = 0;
    flip = 1'b0;
    while (ang > QDEG180) ang -= QDEG360;
    while (ang < -QDEG180) ang += QDEG360;
    if (ang > QDEG90) begin
      ang -= QDEG180;
      flip = 1'b1;
    end else if (ang < -QDEG90) begin
      ang += QDEG180;
      flip = 1'b1;
    end
    z = rshr(ang * DEG_TO_RAD, 26);
    for (int unsigned i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= atan_at(i);
      end else begin
        x += dy; y -= dx; z += atan_at(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC: gain-corrected magnitude, angle in phase.
  function automatic longint magnitude(input longint x, input longint y, output longint phase);
    longint z, dx, dy;
    z = 0;
    for (int unsigned i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_at(i);
      end else begin
        x -= dy; y += dx; z -= atan_at(i);
      end
    end
    phase = z;
    return rshr(x * INV_GAIN, 30);
  endfunction

  function automatic void to_vector(input longint lat, input longint lon, output longint v[3]);
    longint st, ct, sp, cp;
    sine_cosine(QDEG90 - lat, st, ct);
    sine_cosine(lon, sp, cp);
    v[0] = rshr(st * cp, 30);
    v[1] = rshr(st * sp, 30);
    v[2] = ct;
  endfunction

  // Arc in degrees Q16 between two points; raises undet near 180 degrees.
  function automatic longint arc_degrees(input longint lat1, input longint lon1,
                                         input longint lat2, input longint lon2,
                                         inout bit undet);
    longint a[3], b[3];
    longint dot, c0, c1, c2, m, z, arc, deg;
    to_vector(lat1, lon1, a);
    to_vector(lat2, lon2, b);
    dot = rshr(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30);
    c0 = rshr(a[1] * b[2] - a[2] * b[1], 30);
    c1 = rshr(a[2] * b[0] - a[0] * b[2], 30);
    c2 = rshr(a[0] * b[1] - a[1] * b[0], 30);
    if (c0 < 0) c0 = -c0;
    if (c2 < 0) c2 = -c2;
    m = magnitude(c0, c1, z);
    m = magnitude(m, c2, z);
    m = magnitude(m, dot, z);
    arc = HALF_PI - z;
    if (arc < 0) arc = 0;
    if (arc > FULL_PI) arc = FULL_PI;
    deg = rshr(arc * RAD_TO_DEG, 38);
    if (deg > QDEG180) deg = QDEG180;
    if (deg >= QDEG180 - 1) undet = 1'b1;
    return deg;
  endfunction

  // Expected time shift of one candidate under the current register values.
  function automatic shift_result_t predict_shift(input longint lat, input longint lon,
                                                  input longint dep);
    shift_result_t r;
    longint g1, g0, t;
    bit undet;
    undet = 1'b0;
    g1 = arc_degrees(regs_now[REG_STA_LAT], regs_now[REG_STA_LON], lat, lon, undet);
    g0 = arc_degrees(regs_now[REG_STA_LAT], regs_now[REG_STA_LON],
                     regs_now[REG_REF_LAT], regs_now[REG_REF_LON], undet);
    t = rshr(regs_now[REG_ARC_SLW] * (g1 - g0)
             + regs_now[REG_DEP_SLW] * (dep - regs_now[REG_REF_DEP]), 16);
    r.sat = 1'b0;
    if (t > CLIP) begin
      t = CLIP;
      r.sat = 1'b1;
    end else if (t < -CLIP) begin
      t = -CLIP;
      r.sat = 1'b1;
    end
    r.shift = t[TS_W-1:0];
    r.undet = undet;
    return r;
  endfunction

  // Input side: the candidate fields are decoded from every accepted transaction, so the
  // predictor sees exactly what the block took, under the register values of that moment.
  always @(posedge clk_i) begin
    shift_result_t e;
    shift_result_t got;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      e = predict_shift(sx(longint'(s_axis_tdata[23:0]), LAT_W),
                        sx(longint'(s_axis_tdata[48:24]), LON_W),
                        sx(longint'(s_axis_tdata[67:49]), DEP_W));
      // Rows with a typed-in answer replace the predicted shift and saturation.
      if (typed_valid.size() > 0) begin
        if (typed_valid.pop_front()) begin
          got = typed_q.pop_front();
          e.shift = got.shift;
          e.sat = got.sat;
        end
      end
      shift_q.push_back(e);
    end
    // Output side: every accepted result is compared with the oldest expectation.
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.shift = m_axis_tdata[TS_W-1:0];
      got.sat = m_axis_tuser[0];
      got.undet = m_axis_tuser[1];
      if (shift_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected result tdata=%h tuser=%b",
                                    m_axis_tdata, m_axis_tuser);
      end else begin
        e = shift_q.pop_front();
        if (got.shift !== e.shift || got.sat !== e.sat || got.undet !== e.undet ||
            m_axis_tdata[OUT_TDATA_W-1:TS_W] !== '0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: shift exp %h got %h, sat exp %b got %b, undet exp %b got %b",
                     e.shift, m_axis_tdata, e.sat, got.sat, e.undet, got.undet);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one candidate and returns at the edge where it is accepted.
  task automatic send_candidate(input longint lat, input longint lon, input longint dep);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, dep[DEP_W-1:0], lon[LON_W-1:0], lat[LAT_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits for the pipeline to empty, then writes every register (and the unused
  // index, which must be ignored) on consecutive edges. The caller has already
  // dropped s_axis_tvalid.
  task automatic program_regs(input longint vals[NUM_REGS]);
    while (shift_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_data_i <= CFG_DATA_W'(vals[i]);
      @(posedge clk_i);
      regs_now[i] = sx(vals[i], reg_width[i]);
    end
    cfg_idx_i <= REG_UNUSED;
    cfg_data_i <= '1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic longint rand_field(input int unsigned w, input longint lo, input longint hi);
    if ($urandom_range(9) < 7) return lo + longint'($urandom_range(32'(hi - lo)));
    return sx(longint'({$urandom, $urandom}), w);
  endfunction

  // Random candidate: mostly in-range points, some raw bit patterns and a few
  // points on top of or opposite to the station, or at a pole.
  task automatic send_random();
    longint lat, lon, dep;
    int pick;
    pick = $urandom_range(19);
    lat = rand_field(LAT_W, -QDEG90, QDEG90);
    lon = rand_field(LON_W, -QDEG180, QDEG180);
    dep = rand_field(DEP_W, -2560, 204800);
    if (pick == 0) begin
      lat = regs_now[REG_STA_LAT];
      lon = regs_now[REG_STA_LON];
    end else if (pick == 1) begin
      lat = -regs_now[REG_STA_LAT];
      lon = regs_now[REG_STA_LON] + QDEG180;
      if (lon > QDEG180) lon -= QDEG360;
    end else if (pick == 2) begin
      lat = ($urandom_range(1) != 0) ? QDEG90 : -QDEG90;
    end
    send_candidate(lat, lon, dep);
  endtask

  function automatic void add_row(input longint lat, input longint lon, input longint dep,
                                  input bit known, input longint shift);
    probe_row_t r;
    r.lat = lat;
    r.lon = lon;
    r.dep = dep;
    r.known_shift = known;
    r.shift = shift;
    probe_table.push_back(r);
  endfunction

  task automatic walk_table();
    shift_result_t t;
    foreach (probe_table[i]) begin
      typed_valid.push_back(use_typed && probe_table[i].known_shift);
      if (use_typed && probe_table[i].known_shift) begin
        t.shift = TS_W'(probe_table[i].shift);
        t.sat = 1'b0;
        typed_q.push_back(t);
      end
      send_candidate(probe_table[i].lat, probe_table[i].lon, probe_table[i].dep);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    longint cfg_vals[NUM_REGS];
    foreach (regs_now[i]) regs_now[i] = 0;

    // With all slownesses zero after reset the shift is zero for any candidate.
    add_row(0, 0, 0, 1'b1, 0);
    add_row(QDEG90, 0, 204800, 1'b1, 0);
    add_row(-QDEG90, QDEG180, -2560, 1'b1, 0);
    add_row(0, QDEG180, 0, 1'b1, 0);
    add_row(0, -QDEG180, 100, 1'b1, 0);
    add_row(QDEG90, QDEG180, 0, 1'b1, 0);
    add_row(-QDEG90, -QDEG180, 204800, 1'b1, 0);
    add_row(sx(64'h7FFFFF, LAT_W), sx(64'hFFFFFF, LON_W), sx(64'h3FFFF, DEP_W), 1'b1, 0);
    add_row(sx(64'h800000, LAT_W), sx(64'h1000000, LON_W), sx(64'h40000, DEP_W), 1'b1, 0);
    add_row(-1, -1, -1, 1'b1, 0);
    add_row(1, 1, 1, 1'b1, 0);
    add_row(QDEG90 + 65536, 0, 0, 1'b1, 0);
    add_row(QDEG180 / 4, QDEG360 / 3, 51200, 1'b1, 0);
    add_row(-QDEG180 / 4, -QDEG360 / 3, 0, 1'b1, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    use_typed = 1'b1;
    walk_table();
    use_typed = 1'b0;

    // Raw extremes of every register, largest then smallest; reference lat/lon in range.
    cfg_vals = '{sx(64'h7FFFFF, LAT_W), sx(64'hFFFFFF, LON_W), QDEG90, QDEG180,
                 sx(64'h3FFFF, DEP_W), sx(64'h1FFFFF, ASLW_W), sx(64'h1FFFFFF, DSLW_W)};
    program_regs(cfg_vals);
    walk_table();
    cfg_vals = '{sx(64'h800000, LAT_W), sx(64'h1000000, LON_W), -QDEG90, -QDEG180,
                 sx(64'h40000, DEP_W), sx(64'h200000, ASLW_W), sx(64'h2000000, DSLW_W)};
    program_regs(cfg_vals);
    walk_table();

    // Three random phases, each under new, mostly in-range registers and its own idling mix.
    for (int ph = 0; ph < 3; ph++) begin
      cfg_vals = '{rand_field(LAT_W, -QDEG90, QDEG90), rand_field(LON_W, -QDEG180, QDEG180),
                   rand_field(LAT_W, -QDEG90, QDEG90), rand_field(LON_W, -QDEG180, QDEG180),
                   rand_field(DEP_W, -2560, 204800), rand_field(ASLW_W, -1310720, 1310720),
                   rand_field(DSLW_W, -16777216, 16777216)};
      program_regs(cfg_vals);
      tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 76 : 0;
      rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 15 : 0;
      // In the last phase the receiver stops for a long stretch so the pipeline fills.
      if (ph == 2) hold_req = 1'b1;
      repeat (RANDOM_ITEMS) send_random();
      s_axis_tvalid <= 1'b0;
    end

    while (shift_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/gcts_pkg.sv
hw/rtl/gcts_arc.sv
hw/rtl/great_circle_time_shift.sv
hw/rtl/gcts_chk.sv
tb/tb.sv
